[design/fqd_pkg.sv]
package fqd_pkg;

  // Queue geometry
  localparam int DEPTH = 16;
  localparam int VAL_W = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Action codes
  localparam logic [1:0] ACT_ENQ = 2'd0;
  localparam logic [1:0] ACT_DEQ = 2'd1;
  localparam logic [1:0] ACT_DEL = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ,
    S_SEARCH,
    S_SHIFT,
    S_RESP
  } state_t;

  // One read port and one write port into the entry store
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
  } ram_req_t;

  // Slot of the entry at a given offset from the oldest one
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

[design/fifo_queue_with_delete_core.sv]
// Bounded queue of nonzero handles with removal by value.
// Input channel (in_valid/in_ready) carries an action and a value: enqueue,
// dequeue the oldest entry, or delete the first entry equal to the value.
// Output channel (out_valid/out_ready) returns one result per action: status,
// the dequeued handle (zero unless a dequeue succeeded) and the length after.
// One action is in progress at a time; in_ready is high only when idle.
// Enqueue, rejected actions and unused codes go straight to the result;
// a dequeue first reads the store once. A delete searches, reading one
// entry a cycle, then the younger entries are moved down one slot a cycle
// through the single read and write port of the entry store.
// The next action is taken as soon as the result sits in the output
// register; a stalled receiver holds the result and blocks only the
// following result, not the action that produces it.
// Synchronous reset empties the queue at once; the entry store is not
// cleared, since only occupied slots are ever read.
module fifo_queue_with_delete_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                action,
  input  logic [31:0]               value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic [31:0]               dequeued,
  output logic [4:0]                length
);
  import fqd_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] oldest;
  logic [CNT_W-1:0] occ;
  logic [VAL_W-1:0] cmd_val;
  status_t          res_status;
  logic [VAL_W-1:0] res_deq;
  logic [CNT_W-1:0] sc_i;
  logic             pend;
  logic [CNT_W-1:0] pend_off;
  logic [CNT_W-1:0] sh_j;
  logic             wr_pend;
  logic [CNT_W-1:0] wr_off;

  ram_req_t         ram_req;
  logic [VAL_W-1:0] rdata;

  logic in_xfer, out_xfer, out_load;
  logic in_zero, q_empty, q_full;
  logic sc_rd, match, sc_last, sh_rd, sh_done;

  fqd_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  // Handshake and status flags
  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign out_load = (state == S_RESP) && (!out_valid || out_ready);
  assign in_zero  = (value == '0);
  assign q_empty  = (occ == '0);
  assign q_full   = (occ == CNT_W'(DEPTH));

  // Search and shift progress
  assign sc_rd   = (sc_i < occ);
  assign match   = pend && (rdata == cmd_val);
  assign sc_last = pend && (pend_off == occ - CNT_W'(1));
  assign sh_rd   = (sh_j < occ);
  assign sh_done = !sh_rd && !wr_pend;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          priority if (action == ACT_DEQ && !q_empty) begin
            state_next = S_DEQ;
          end else if (action == ACT_DEL && !in_zero && !q_empty) begin
            state_next = S_SEARCH;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_DEQ: state_next = S_RESP;
      S_SEARCH: begin
        priority if (match) begin
          state_next = S_SHIFT;
        end else if (sc_last) begin
          state_next = S_RESP;
        end
      end
      S_SHIFT: begin
        if (sh_done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Entry store accesses
  always_comb begin
    ram_req = '0;
    ram_req.wr_data = value;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && action == ACT_ENQ && !in_zero && !q_full) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = ring_pos(oldest, occ);
        end
        if (in_xfer && action == ACT_DEQ && !q_empty) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = oldest;
        end
      end
      S_SEARCH: begin
        ram_req.rd_en   = sc_rd;
        ram_req.rd_addr = ring_pos(oldest, sc_i);
      end
      S_SHIFT: begin
        ram_req.rd_en   = sh_rd;
        ram_req.rd_addr = ring_pos(oldest, sh_j);
        ram_req.wr_en   = wr_pend;
        ram_req.wr_addr = ring_pos(oldest, wr_off);
        ram_req.wr_data = rdata;
      end
      default: begin
        ram_req.rd_en = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      oldest    <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_xfer && action == ACT_ENQ && !in_zero && !q_full) begin
        occ <= occ + CNT_W'(1);
      end
      if (state == S_DEQ) begin
        oldest <= ring_pos(oldest, CNT_W'(1));
        occ    <= occ - CNT_W'(1);
      end
      if (state == S_SHIFT && sh_done) begin
        occ <= occ - CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current action
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cmd_val  <= value;
        res_deq  <= '0;
        sc_i     <= '0;
        pend     <= 1'b0;
        wr_pend  <= 1'b0;
        res_status <= ST_OK;
        unique case (action)
          ACT_ENQ: begin
            if (in_zero) begin
              res_status <= ST_ZERO;
            end else if (q_full) begin
              res_status <= ST_FULL;
            end
          end
          ACT_DEQ: begin
            if (q_empty) begin
              res_status <= ST_EMPTY;
            end
          end
          ACT_DEL: begin
            if (in_zero) begin
              res_status <= ST_ZERO;
            end else if (q_empty) begin
              res_status <= ST_EMPTY;
            end
          end
          default: res_status <= ST_OK;
        endcase
      end
      S_DEQ: begin
        res_deq <= rdata;
      end
      S_SEARCH: begin
        pend     <= sc_rd;
        pend_off <= sc_i;
        sc_i     <= sc_i + CNT_W'(1);
        sh_j     <= pend_off + CNT_W'(1);
        wr_pend  <= 1'b0;
        if (sc_last && !match) begin
          res_status <= ST_NOT_FOUND;
        end
      end
      S_SHIFT: begin
        wr_pend <= sh_rd;
        wr_off  <= sh_j - CNT_W'(1);
        sh_j    <= sh_j + CNT_W'(1);
      end
      default: begin
        pend <= 1'b0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      status   <= res_status;
      dequeued <= res_deq;
      length   <= 5'(occ);
    end
  end

endmodule

[design/fqd_ram.sv]
module fqd_ram (
  input  logic                     clk,
  input  fqd_pkg::ram_req_t        req,
  output logic [fqd_pkg::VAL_W-1:0] rdata
);
  import fqd_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule
